// ----- design/sbc_pkg.sv -----
`timescale 1ns / 1ps

package sbc_pkg;

    // fixed field widths
    localparam int CFG_DIM_W   = 7;
    localparam int COLOR_W     = 16;
    localparam int ORIGIN_W    = 11;
    localparam int PIX_X_W     = 9;
    localparam int PIX_Y_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    // reset values of the configuration registers
    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 7'd32;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 7'd32;
    localparam logic [COLOR_W-1:0]   KEY_RESET    = 16'd0;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPRITE_WIDTH    = 2'd0,
        REG_SPRITE_HEIGHT   = 2'd1,
        REG_TRANSPARENT_KEY = 2'd2
    } cfg_reg_t;

    // input tdata layout, lowest field last
    typedef struct packed {
        logic                       pad;
        logic [COLOR_W-1:0]         color;
        logic                       mirror;
        logic signed [ORIGIN_W-1:0] origin_y;
        logic signed [ORIGIN_W-1:0] origin_x;
    } in_beat_t;

    // output tdata layout, lowest field last
    typedef struct packed {
        logic [6:0]         pad;
        logic [COLOR_W-1:0] pixel_color;
        logic [PIX_Y_W-1:0] pixel_y;
        logic [PIX_X_W-1:0] pixel_x;
    } out_beat_t;

endpackage

// ----- design/sprite_blit_color_key_flip_clip.sv -----
`timescale 1ns / 1ps

// Color-keyed sprite blitter with horizontal mirror and screen clipping.
// The s_ channel carries source pixels of a sprite in row-major order, one
// per beat, with the sprite's screen origin and a mirror flag; s_tuser marks
// the first pixel of a new sprite and restarts the column and row counters.
// The m_ channel carries one screen write (x, y, color) for each pixel that
// is not the transparent key and lands on the screen; other beats vanish.
// Width, height and key are set through the cfg_ write port; the user must
// write them only while idle, which the block itself does not enforce.
// An accepted beat passes through the input register, then the result
// register, before its write shows on m_.
// Throughput: one beat per cycle while the receiver does not stall, set by the two-stage register pipeline.
// Reset clears both counters, both valid flags and restores width 32,
// height 32 and key 0. When the receiver stalls, the result register holds
// its beat and the input register holds the next one, whether or not it
// makes a write; s_tready drops only while both registers are full.

module sprite_blit_color_key_flip_clip import sbc_pkg::*; #(
    parameter int SCREEN_W = 320,
    parameter int SCREEN_H = 240,
    parameter int MAX_DIM  = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // origin_x, origin_y, mirror, color
    input  logic                   s_tuser,   // start_req
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // pixel_x, pixel_y, pixel_color
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CW    = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;

    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [COLOR_W-1:0]   key_reg;
    logic [CW-1:0]        w_raw, h_raw, w_eff, h_eff;

    logic                 s1_valid_reg, s1_valid_next;
    in_beat_t             s1_beat_reg;
    logic [CNT_W-1:0]     s1_col_reg, s1_row_reg;
    logic                 m_valid_reg, m_valid_next;
    out_beat_t            m_beat_reg;

    in_beat_t             in_beat;
    logic                 in_accept;
    logic                 out_free;
    logic [CNT_W-1:0]     pos_col, pos_row;
    out_beat_t            place_pix;
    logic                 place_visible;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            key_reg    <= KEY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_SPRITE_WIDTH:    width_reg  <= cfg_wdata[CFG_DIM_W-1:0];
                REG_SPRITE_HEIGHT:   height_reg <= cfg_wdata[CFG_DIM_W-1:0];
                REG_TRANSPARENT_KEY: key_reg    <= cfg_wdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize acts as the largest sprite
    always_comb begin
        w_raw = CW'(width_reg);
        h_raw = CW'(height_reg);
        if (w_raw == '0) begin
            w_eff = CW'(1);
        end else if (w_raw > CW'(MAX_DIM)) begin
            w_eff = CW'(MAX_DIM);
        end else begin
            w_eff = w_raw;
        end
        if (h_raw == '0) begin
            h_eff = CW'(1);
        end else if (h_raw > CW'(MAX_DIM)) begin
            h_eff = CW'(MAX_DIM);
        end else begin
            h_eff = h_raw;
        end
    end

    // handshake: result register frees when empty or taken
    assign in_beat   = in_beat_t'(s_tdata);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || out_free;
    assign in_accept = s_tvalid && s_tready;

    sbc_pos_counter #(
        .CNT_W (CNT_W),
        .CW    (CW)
    ) u_counter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_accept),
        .start   (s_tuser),
        .dim_w   (w_eff),
        .dim_h   (h_eff),
        .pos_col (pos_col),
        .pos_row (pos_row)
    );

    // input register
    assign s1_valid_next = in_accept || (s1_valid_reg && !out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_beat_reg <= in_beat;
            s1_col_reg  <= pos_col;
            s1_row_reg  <= pos_row;
        end
    end

    sbc_placer #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H),
        .CNT_W    (CNT_W),
        .CW       (CW)
    ) u_placer (
        .beat    (s1_beat_reg),
        .col     (s1_col_reg),
        .row     (s1_row_reg),
        .dim_w   (w_eff),
        .key     (key_reg),
        .pix     (place_pix),
        .visible (place_visible)
    );

    // result register
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (out_free && s1_valid_reg && place_visible) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_valid_reg && place_visible) begin
            m_beat_reg <= place_pix;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_beat_reg);

    // result register empties at reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid_reg)
        else $error("result valid set after reset");

    // a visible pixel leaving the input register always lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_free && place_visible) |=> m_valid_reg)
        else $error("visible pixel lost");

    // input stalls only while both registers are full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_valid_reg))
        else $error("input stalled with room");

    // a write always lies on the screen when coordinates fit the fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (SCREEN_W <= 512) && (SCREEN_H <= 256)) |->
        ((32'(m_beat_reg.pixel_x) < SCREEN_W) && (32'(m_beat_reg.pixel_y) < SCREEN_H)))
        else $error("write off screen");

endmodule

// ----- design/sbc_pos_counter.sv -----
`timescale 1ns / 1ps

module sbc_pos_counter import sbc_pkg::*; #(
    parameter int CNT_W = 6,
    parameter int CW    = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             start,
    input  logic [CW-1:0]    dim_w,
    input  logic [CW-1:0]    dim_h,
    output logic [CNT_W-1:0] pos_col,
    output logic [CNT_W-1:0] pos_row
);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CW-1:0]    col_inc;
    logic [CW-1:0]    row_inc;

    // a start beat sits at the sprite's top-left corner
    assign pos_col = start ? '0 : col_reg;
    assign pos_row = start ? '0 : row_reg;

    // step with wrap on reached-or-passed
    always_comb begin
        col_inc  = CW'(pos_col) + CW'(1);
        row_inc  = CW'(pos_row);
        col_next = CNT_W'(col_inc);
        if (col_inc >= dim_w) begin
            col_next = '0;
            row_inc  = CW'(pos_row) + CW'(1);
        end
        row_next = CNT_W'(row_inc);
        if (row_inc >= dim_h) begin
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (step) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- design/sbc_placer.sv -----
`timescale 1ns / 1ps

module sbc_placer import sbc_pkg::*; #(
    parameter int SCREEN_W = 320,
    parameter int SCREEN_H = 240,
    parameter int CNT_W    = 6,
    parameter int CW       = 7
) (
    input  in_beat_t         beat,
    input  logic [CNT_W-1:0] col,
    input  logic [CNT_W-1:0] row,
    input  logic [CW-1:0]    dim_w,
    input  logic [COLOR_W-1:0] key,
    output out_beat_t        pix,
    output logic             visible
);

    localparam int XW = ((CW > ORIGIN_W) ? CW : ORIGIN_W) + 3;

    logic signed [XW-1:0] ox_ext;
    logic signed [XW-1:0] oy_ext;
    logic signed [XW-1:0] col_ext;
    logic signed [XW-1:0] row_ext;
    logic signed [XW-1:0] w_ext;
    logic signed [XW-1:0] x_pos;
    logic signed [XW-1:0] y_pos;
    logic                 on_screen;

    // screen position, mirrored about the sprite's own width
    always_comb begin
        ox_ext  = XW'(beat.origin_x);
        oy_ext  = XW'(beat.origin_y);
        col_ext = $signed(XW'(col));
        row_ext = $signed(XW'(row));
        w_ext   = $signed(XW'(dim_w));
        if (beat.mirror) begin
            x_pos = ox_ext + w_ext - $signed(XW'(1)) - col_ext;
        end else begin
            x_pos = ox_ext + col_ext;
        end
        y_pos = oy_ext + row_ext;
    end

    // clip to the screen and drop keyed pixels
    assign on_screen = (x_pos >= $signed(XW'(0))) && (x_pos < $signed(XW'(SCREEN_W)))
                    && (y_pos >= $signed(XW'(0))) && (y_pos < $signed(XW'(SCREEN_H)));
    assign visible   = (beat.color != key) && on_screen;

    always_comb begin
        pix             = '0;
        pix.pixel_x     = x_pos[PIX_X_W-1:0];
        pix.pixel_y     = y_pos[PIX_Y_W-1:0];
        pix.pixel_color = beat.color;
    end

endmodule
